/* rtl/rau_pkg.sv */
package rau_pkg;

  localparam int unsigned DW = 32;  // divider operand width

  localparam logic [1:0] FN_ADD = 2'd0;
  localparam logic [1:0] FN_SUB = 2'd1;
  localparam logic [1:0] FN_MUL = 2'd2;
  localparam logic [1:0] FN_DIV = 2'd3;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } dv_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quo;
    logic [DW-1:0] rem;
  } dv_rsp_t;

endpackage

/* rtl/rau_div.sv */
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module rau_div
  import rau_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  dv_req_t req,
  output dv_rsp_t rsp
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [DW-1:0] rem;

  logic [DW:0]   sh;
  logic [DW+1:0] diff;
  logic          neg;

  assign sh   = {rem, quo[DW-1]};
  assign diff = {1'b0, sh} - {2'b00, dvs};
  assign neg  = diff[DW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dvs <= req.divisor;
      quo <= req.dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ~neg};
      rem <= neg ? sh[DW-1:0] : diff[DW-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

/* rtl/rational_arithmetic_unit.sv */
// Rational arithmetic unit: a_num/a_den (op) b_num/b_den, reduced to lowest terms.
// Input channel: in_valid/in_ready carry func, a_num, a_den, b_num, b_den.
// Output channel: out_valid/out_ready carry res_num, res_den, div_zero.
// One transaction in, one transaction out, strictly in order.
// in_ready is high only while the sequencer is idle; one item is worked at a time.
// Latency is data dependent. Every division goes through one shared restoring
// divider. Add/subtract: Euclid gcd of the denominators, two quotient divides,
// three multiply steps; every operation with a nonzero result then runs Euclid
// on the result and two final divides. Each Euclid step is one divider call
// plus a pass through the S_GCD state, up to about 22 steps on the denominators
// and about 45 on the result. Error cases (zero denominator, division by zero)
// skip all of these, and a zero result of any operation skips the result Euclid
// and the final divides.
// A zero result is 0/1; an error gives 0/0 with div_zero set.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
// A finished result sits in the output register; the next item can be taken
// while it waits, but that item's result is held until out_ready frees it.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [15:0] a_num,
  input  logic [14:0]        a_den,
  input  logic signed [15:0] b_num,
  input  logic [14:0]        b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [32:0] res_num,
  output logic [30:0]        res_den,
  output logic               div_zero
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_CHK  = 16'h0002,
    S_GCD  = 16'h0004,
    S_GW   = 16'h0008,
    S_DVA  = 16'h0010,
    S_WA   = 16'h0020,
    S_WB   = 16'h0040,
    S_P1   = 16'h0080,
    S_P2   = 16'h0100,
    S_P3   = 16'h0200,
    S_SUM  = 16'h0400,
    S_ZCHK = 16'h0800,
    S_DVN  = 16'h1000,
    S_WN   = 16'h2000,
    S_WD   = 16'h4000,
    S_FIN  = 16'h8000
  } state_t;

  state_t state;

  // operand registers
  logic [1:0]         fn;
  logic signed [15:0] an;
  logic signed [15:0] bn;
  logic [14:0]        ad;
  logic [14:0]        bd;

  // work registers
  logic [DW-1:0]      x;      // Euclid pair, x ends as the gcd
  logic [DW-1:0]      y;
  logic               phase;  // 0: denominator gcd, 1: result gcd
  logic [14:0]        qa;     // a_den / g
  logic [14:0]        qb;     // b_den / g
  logic [DW-1:0]      qn;
  logic [DW-1:0]      nabs;
  logic               neg;
  logic signed [32:0] num;
  logic signed [32:0] tb;
  logic [30:0]        den;
  logic               err;

  dv_req_t dv_req;
  dv_rsp_t dv_rsp;

  rau_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dv_req),
    .rsp (dv_rsp)
  );

  // shared multiplier, 17x17 signed, result registered by the state that uses it
  logic signed [16:0] ma;
  logic signed [16:0] mb;
  logic signed [33:0] prod;
  logic signed [16:0] an_x;
  logic signed [16:0] bn_x;
  logic signed [16:0] bd_x;
  logic signed [16:0] bmag;
  logic signed [32:0] mag;
  logic               addsub;

  assign an_x   = {an[15], an};
  assign bn_x   = {bn[15], bn};
  assign bd_x   = {2'b00, bd};
  assign bmag   = bn[15] ? -bn_x : bn_x;
  assign addsub = (fn == FN_ADD) || (fn == FN_SUB);
  assign mag    = num[32] ? -num : num;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_P1: begin
        if (addsub) begin
          ma = {2'b00, qa};
          mb = bd_x;
        end else begin
          ma = {2'b00, ad};
          mb = (fn == FN_MUL) ? bd_x : bmag;
        end
      end
      S_P2: begin
        if (addsub) begin
          ma = {2'b00, qb};
          mb = an_x;
        end else begin
          ma = an_x;
          mb = (fn == FN_MUL) ? bn_x : (bn[15] ? -bd_x : bd_x);
        end
      end
      S_P3: begin
        ma = {2'b00, qa};
        mb = bn_x;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // divider requests
  always_comb begin
    dv_req = '0;
    case (state)
      S_GCD: begin
        dv_req.start    = (y != '0);
        dv_req.dividend = x;
        dv_req.divisor  = y;
      end
      S_DVA: begin
        dv_req.start    = 1'b1;
        dv_req.dividend = DW'(ad);
        dv_req.divisor  = x;
      end
      S_WA: begin
        dv_req.start    = dv_rsp.done;
        dv_req.dividend = DW'(bd);
        dv_req.divisor  = x;
      end
      S_DVN: begin
        dv_req.start    = 1'b1;
        dv_req.dividend = nabs;
        dv_req.divisor  = x;
      end
      S_WN: begin
        dv_req.start    = dv_rsp.done;
        dv_req.dividend = DW'(den);
        dv_req.divisor  = x;
      end
      default: dv_req = '0;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output register loads in S_FIN once free, else clears on acceptance
      if (state == S_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready)                                out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) state <= S_CHK;
        S_CHK: begin
          if (ad == '0 || bd == '0 || (fn == FN_DIV && bn == '0)) state <= S_FIN;
          else if (addsub)                                        state <= S_GCD;
          else                                                    state <= S_P1;
        end
        S_GCD: begin
          if (y == '0) state <= phase ? S_DVN : S_DVA;
          else         state <= S_GW;
        end
        S_GW:   if (dv_rsp.done) state <= S_GCD;
        S_DVA:  state <= S_WA;
        S_WA:   if (dv_rsp.done) state <= S_WB;
        S_WB:   if (dv_rsp.done) state <= S_P1;
        S_P1:   state <= S_P2;
        S_P2:   state <= addsub ? S_P3 : S_ZCHK;
        S_P3:   state <= S_SUM;
        S_SUM:  state <= S_ZCHK;
        S_ZCHK: state <= (num == '0) ? S_FIN : S_GCD;
        S_DVN:  state <= S_WN;
        S_WN:   if (dv_rsp.done) state <= S_WD;
        S_WD:   if (dv_rsp.done) state <= S_FIN;
        S_FIN:  if (!out_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          fn <= func;
          an <= a_num;
          ad <= a_den;
          bn <= b_num;
          bd <= b_den;
        end
      end
      S_CHK: begin
        err <= 1'b0;
        if (ad == '0 || bd == '0 || (fn == FN_DIV && bn == '0)) begin
          num <= '0;
          den <= '0;
          err <= 1'b1;
        end else begin
          x     <= DW'(ad);
          y     <= DW'(bd);
          phase <= 1'b0;
        end
      end
      S_GW: begin
        if (dv_rsp.done) begin
          x <= y;
          y <= dv_rsp.rem;
        end
      end
      S_WA:  if (dv_rsp.done) qa <= dv_rsp.quo[14:0];
      S_WB:  if (dv_rsp.done) qb <= dv_rsp.quo[14:0];
      S_P1:  den <= prod[30:0];
      S_P2:  num <= prod[32:0];
      S_P3:  tb  <= prod[32:0];
      S_SUM: num <= (fn == FN_SUB) ? num - tb : num + tb;
      S_ZCHK: begin
        if (num == '0) begin
          den <= 31'd1;
        end else begin
          neg   <= num[32];
          nabs  <= mag[DW-1:0];
          x     <= mag[DW-1:0];
          y     <= DW'(den);
          phase <= 1'b1;
        end
      end
      S_WN: if (dv_rsp.done) qn <= dv_rsp.quo;
      S_WD: begin
        if (dv_rsp.done) begin
          den <= dv_rsp.quo[30:0];
          num <= neg ? -{1'b0, qn} : {1'b0, qn};
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          res_num  <= num;
          res_den  <= den;
          div_zero <= err;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/rau_chk.sv */
module rau_chk
  import rau_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [32:0] res_num,
  input logic [30:0]        res_den,
  input logic               div_zero
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(res_den))
    else $error("stalled result changed");

  // one transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> res_num == '0)
    else $error("error result has nonzero numerator");

  a_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && !div_zero |-> res_den != '0)
    else $error("zero denominator without error");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !div_zero && res_num == '0 |-> res_den == 31'd1)
    else $error("zero result not 0/1");

endmodule

bind rational_arithmetic_unit rau_chk u_rau_chk (.*);

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  // Fraction ALU check: directed table of corner operations, then random
  // transactions; every result is predicted in-bench and compared in order.

  localparam int unsigned N_RANDOM     = 500;
  localparam int unsigned STALL_LIMIT  = 40000;  // watchdog bound on cycles with no accepted transaction
  localparam int unsigned DRAIN_CYCLES = 3500;

  typedef struct packed {
    logic [1:0]  fn;
    logic [15:0] an;
    logic [14:0] ad;
    logic [15:0] bn;
    logic [14:0] bd;
  } frac_op_t;

  typedef struct packed {
    logic [32:0] num;
    logic [30:0] den;
    logic        dz;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = FN_ADD;
  logic signed [15:0] a_num = '0;
  logic [14:0] a_den = 15'd1;
  logic signed [15:0] b_num = '0;
  logic [14:0] b_den = 15'd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [32:0] res_num;
  logic [30:0] res_den;
  logic div_zero;

  frac_res_t pending_q[$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned n_dz = 0;
  int unsigned idle_cycles = 0;
  bit hold_off = 1'b0;   // long receiver stall requested by the sender
  bit tail_mode = 1'b0;  // last part of the run: no idling

  always #6 clk = ~clk;

  rational_arithmetic_unit u_top (.*);

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Reduced fraction for one operation.
  function automatic frac_res_t reduce_frac(frac_op_t t);
    frac_res_t r;
    longint an, bn, num, ta, tb;
    longint unsigned ad, bd, den, g, l, mag;
    an = longint'($signed(t.an));
    bn = longint'($signed(t.bn));
    ad = t.ad;
    bd = t.bd;
    r = '0;
    if (ad == 0 || bd == 0) begin
      r.dz = 1'b1;
      return r;
    end
    case (t.fn)
      FN_ADD, FN_SUB: begin
        g = euclid(ad, bd);
        l = ad / g * bd;
        ta = longint'(l / ad) * an;
        tb = longint'(l / bd) * bn;
        num = (t.fn == FN_ADD) ? ta + tb : ta - tb;
        den = l;
      end
      FN_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        if (bn == 0) begin
          r.dz = 1'b1;
          return r;
        end
        num = an * longint'(bd);
        if (bn < 0) num = -num;
        den = ad * ((bn < 0) ? -bn : bn);
      end
    endcase
    if (num == 0) begin
      r.den = 31'd1;
      return r;
    end
    mag = (num < 0) ? -num : num;
    g = euclid(mag, den);
    num = num / longint'(g);
    den = den / g;
    r.num = num[32:0];
    r.den = den[30:0];
    return r;
  endfunction

  // One transaction on the input channel; the expectation is queued on acceptance.
  task automatic send_op(frac_op_t t);
    @(negedge clk);
    in_valid <= 1'b1;
    func <= t.fn;
    a_num <= t.an;
    a_den <= t.ad;
    b_num <= t.bn;
    b_den <= t.bd;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(reduce_frac(t));
    n_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic sender_gap();
    int unsigned n;
    if (!tail_mode && $urandom_range(3) == 0) begin
      n = $urandom_range(15, 1);
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [14:0] rand_den();
    case ($urandom_range(5))
      0: return 15'd1;
      1: return 15'h7fff;
      2: return 15'($urandom_range(12, 1));
      3: return 15'(1 << $urandom_range(14));
      default: return 15'($urandom_range(32767, 1));
    endcase
  endfunction

  function automatic logic [15:0] rand_num();
    case ($urandom_range(6))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'($signed($urandom_range(24)) - 12);
      default: return 16'($urandom);
    endcase
  endfunction

  // Results are checked on the rising edge.
  always @(posedge clk) begin
    frac_res_t want;
    if (!rst && out_valid && out_ready) begin
      n_recv++;
      if (div_zero) n_dz++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %0d/%0d dz=%0b", res_num, res_den, div_zero);
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        if (res_num !== want.num) begin
          $error("res_num expected %0d actual %0d", $signed(want.num), res_num);
          n_errors++;
        end
        if (res_den !== want.den) begin
          $error("res_den expected %0d actual %0d", want.den, res_den);
          n_errors++;
        end
        if (div_zero !== want.dz) begin
          $error("div_zero expected %0b actual %0b", want.dz, div_zero);
          n_errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off counted here.
  initial begin
    int unsigned n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
      end else if (!tail_mode && $urandom_range(4) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(15, 1);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog on cycles with no accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // Directed rows: expected value typed where it is obvious, else predicted.
  typedef struct {
    frac_op_t  op;
    bit        known;
    frac_res_t res;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{'{FN_ADD, 16'd0, 15'd1, 16'd0, 15'd1}, 1, '{33'd0, 31'd1, 1'b0}},
    '{'{FN_ADD, 16'd1, 15'd2, 16'd1, 15'd2}, 1, '{33'd1, 31'd1, 1'b0}},
    '{'{FN_SUB, 16'd3, 15'd4, 16'd3, 15'd4}, 1, '{33'd0, 31'd1, 1'b0}},
    '{'{FN_SUB, 16'd1, 15'd3, 16'd1, 15'd2}, 0, '{33'd0, 31'd0, 1'b0}},
    '{'{FN_MUL, 16'd0, 15'd5, 16'h8000, 15'd7}, 1, '{33'd0, 31'd1, 1'b0}},
    '{'{FN_MUL, 16'h8000, 15'd1, 16'h8000, 15'd1}, 1, '{33'h040000000, 31'd1, 1'b0}},
    '{'{FN_MUL, 16'h7fff, 15'h7fff, 16'h8000, 15'h7fff}, 0, '{33'd0, 31'd0, 1'b0}},
    '{'{FN_MUL, 16'd1, 15'h7fff, 16'd1, 15'h7ffe}, 0, '{33'd0, 31'd0, 1'b0}},
    '{'{FN_DIV, 16'd5, 15'd3, 16'd0, 15'd9}, 1, '{33'd0, 31'd0, 1'b1}},
    '{'{FN_DIV, 16'd0, 15'd3, 16'd4, 15'd9}, 1, '{33'd0, 31'd1, 1'b0}},
    '{'{FN_DIV, 16'd1, 15'd2, 16'hffff, 15'd1}, 0, '{33'd0, 31'd0, 1'b0}},
    '{'{FN_DIV, 16'h8000, 15'd1, 16'h8000, 15'd1}, 1, '{33'd1, 31'd1, 1'b0}},
    '{'{FN_DIV, 16'd1, 15'h7fff, 16'h8000, 15'h7fff}, 0, '{33'd0, 31'd0, 1'b0}},
    '{'{FN_ADD, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7ffe}, 0, '{33'd0, 31'd0, 1'b0}},
    '{'{FN_SUB, 16'h8000, 15'h7fff, 16'h7fff, 15'h7ffd}, 0, '{33'd0, 31'd0, 1'b0}},
    // zero denominators are errors for every operation
    '{'{FN_ADD, 16'd1, 15'd0, 16'd1, 15'd1}, 1, '{33'd0, 31'd0, 1'b1}},
    '{'{FN_SUB, 16'd1, 15'd1, 16'd1, 15'd0}, 1, '{33'd0, 31'd0, 1'b1}},
    '{'{FN_MUL, 16'd2, 15'd0, 16'd3, 15'd0}, 1, '{33'd0, 31'd0, 1'b1}},
    '{'{FN_DIV, 16'd2, 15'd0, 16'd3, 15'd5}, 1, '{33'd0, 31'd0, 1'b1}},
    '{'{FN_MUL, 16'hffff, 15'd1, 16'd1, 15'd1}, 1, '{33'h1ffffffff, 31'd1, 1'b0}}
  };

  // Stimulus.
  initial begin
    frac_op_t t;
    int unsigned k;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known && reduce_frac(dir_rows[i].op) != dir_rows[i].res) begin
        $error("directed row %0d: typed result disagrees with predictor", i);
        n_errors++;
      end
      send_op(dir_rows[i].op);
      sender_gap();
    end

    for (k = 0; k < N_RANDOM; k++) begin
      // long receiver hold-off while the sender keeps offering
      if (k == 100) hold_off = 1'b1;
      // sender pause until every result is back
      if (k == 250) wait (pending_q.size() == 0);
      if (k == N_RANDOM - 80) tail_mode = 1'b1;
      t.fn = 2'($urandom_range(3));
      t.an = rand_num();
      t.bn = rand_num();
      t.ad = rand_den();
      t.bd = rand_den();
      if ($urandom_range(40) == 0) t.ad = '0;
      if ($urandom_range(40) == 0) t.bd = '0;
      send_op(t);
      sender_gap();
    end

    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transactions (%0d directed), %0d results, %0d error/div-zero",
             n_sent, dir_rows.size(), n_recv, n_dz);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
